/* hw/rtl/htfd_pkg.sv */
// Shared types, constants and CRC function for the humidity/temperature frame decoder.
package htfd_pkg;

   localparam logic [7:0]  CRC_POLY      = 8'h31;
   localparam logic [7:0]  CRC_INIT      = 8'hFF;
   localparam logic [7:0]  CRC_TOPBIT    = 8'h80;
   localparam logic [16:0] RAW_FULL      = 17'd65535;
   localparam logic [10:0] TEMP_SPAN_X10 = 11'd1750;
   localparam logic [11:0] TEMP_BASE_X10 = 12'd450;
   localparam logic [6:0]  HUM_SPAN      = 7'd100;

   localparam int TEMP_PROD_W = 27;
   localparam int HUM_PROD_W  = 23;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } htfd_req_type;

   typedef struct packed {
      logic signed [11:0] temperature_tenths;
      logic [6:0]         humidity_percent;
      logic               temperature_ok;
      logic               humidity_ok;
   } htfd_rsp_type;

   // CRC-8, MSB first, one byte per call
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOPBIT) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/humidity_temp_frame_decoder.sv */
// A result passes the h1 and h2 conversion registers into the output register after byte 5 of its frame transfers.
// Throughput: one byte per cycle; byte 5 is held off only while the previous result is
//    still in the conversion pipe or waits in the output register.
// Conversions multiply by the span, then divide by 65535 through shift, add and one compare-and-increment correction.
// Reset (synchronous, active high) returns to idle, CRC to 0xFF, stored values to zero.
module humidity_temp_frame_decoder
   import htfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  htfd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output htfd_rsp_type rsp_data
);

   localparam logic [2:0] POS_IDLE     = 3'd0;
   localparam logic [2:0] POS_TEMP_LO  = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_HI   = 3'd3;
   localparam logic [2:0] POS_HUM_LO   = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   // frame state
   logic [2:0]         pos_ff, pos_in;
   logic [7:0]         crc_ff, crc_in;
   logic [15:0]        word_ff, word_in;
   logic               tpass_ff, tpass_in;
   logic signed [11:0] temp_ff;
   logic [6:0]         hum_ff;

   // temperature conversion pipe
   logic                   t1_vld_ff;
   logic [TEMP_PROD_W-1:0] t1_prod_ff;
   logic                   t2_vld_ff;
   logic [10:0]            t2_q_ff;
   logic [16:0]            t2_r_ff;

   // humidity conversion and result pipe
   logic                  h1_vld_ff;
   logic [HUM_PROD_W-1:0] h1_prod_ff;
   logic                  h1_ok_ff;
   logic                  h1_tok_ff;
   logic signed [11:0]    h1_temp_ff;
   logic                  h2_vld_ff;
   logic [6:0]            h2_q_ff;
   logic [16:0]           h2_r_ff;
   logic                  h2_ok_ff;
   logic                  h2_tok_ff;
   logic signed [11:0]    h2_temp_ff;

   logic         rsp_valid_ff;
   htfd_rsp_type rsp_data_ff;

   logic        req_fire;
   logic        last_byte;
   logic [2:0]  cur_pos;
   logic        t_go;
   logic        h_go;
   logic        hum_ok;
   logic [7:0]  b;

   logic        t_ge;
   logic [10:0] t_qf;
   logic        t_nz;
   logic        t_neg;
   logic [11:0] t_calc;
   logic [6:0]  h_pct;

   assign b         = req_data.data_byte;
   assign last_byte = !req_data.frame_start && (pos_ff == POS_HUM_CRC);
   // byte 5 only enters when the result path is empty, so the output register is free
   assign req_ready = !(last_byte && (rsp_valid_ff || h1_vld_ff || h2_vld_ff));
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      word_in  = word_ff;
      tpass_in = tpass_ff;
      t_go     = 1'b0;
      h_go     = 1'b0;
      hum_ok   = 1'b0;
      cur_pos  = req_data.frame_start ? POS_IDLE : pos_ff;
      if (req_fire) begin
         if (!req_data.frame_start && (pos_ff == POS_IDLE || pos_ff > POS_HUM_CRC)) begin
            pos_in = POS_IDLE;   // stray byte
         end else begin
            pos_in = cur_pos + 3'd1;
            case (cur_pos)
               POS_IDLE, POS_HUM_HI: begin
                  crc_in  = crc8_feed(CRC_INIT, b);
                  word_in = {b, 8'h00};
               end
               POS_TEMP_LO, POS_HUM_LO: begin
                  crc_in  = crc8_feed(crc_ff, b);
                  word_in = {word_ff[15:8], b};
               end
               POS_TEMP_CRC: begin
                  tpass_in = (crc_ff == b);
                  t_go     = (crc_ff == b);
               end
               POS_HUM_CRC: begin
                  h_go   = 1'b1;
                  hum_ok = (crc_ff == b);
                  pos_in = POS_IDLE;
               end
               default: begin
                  pos_in = POS_IDLE;
               end
            endcase
         end
      end
   end

   // x / 65535: q = x >> 16, remainder = low half + q, then one correction
   always_comb begin
      t_ge   = (t2_r_ff >= RAW_FULL);
      t_qf   = t2_q_ff + 11'(t_ge);
      t_nz   = (t2_r_ff != 17'd0) && (t2_r_ff != RAW_FULL);
      t_neg  = (t_qf < 11'(TEMP_BASE_X10));
      // negative quotients truncate toward zero: round up when inexact
      t_calc = 12'(t_qf) - TEMP_BASE_X10 + 12'(t_neg && t_nz);
      h_pct  = h2_q_ff + 7'(h2_r_ff >= RAW_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_IDLE;
         crc_ff       <= CRC_INIT;
         word_ff      <= 16'h0000;
         tpass_ff     <= 1'b0;
         temp_ff      <= 12'sd0;
         hum_ff       <= 7'd0;
         t1_vld_ff    <= 1'b0;
         t2_vld_ff    <= 1'b0;
         h1_vld_ff    <= 1'b0;
         h2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         word_ff   <= word_in;
         tpass_ff  <= tpass_in;
         t1_vld_ff <= t_go;
         t2_vld_ff <= t1_vld_ff;
         h1_vld_ff <= h_go;
         h2_vld_ff <= h1_vld_ff;
         if (t2_vld_ff) begin
            temp_ff <= signed'(t_calc);
         end
         if (h2_vld_ff && h2_ok_ff) begin
            hum_ff <= h_pct;
         end
         if (h2_vld_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      t1_prod_ff <= TEMP_PROD_W'(TEMP_SPAN_X10) * TEMP_PROD_W'(word_ff);
      t2_q_ff    <= t1_prod_ff[TEMP_PROD_W-1:16];
      t2_r_ff    <= {1'b0, t1_prod_ff[15:0]} + 17'(t1_prod_ff[TEMP_PROD_W-1:16]);
      h1_prod_ff <= HUM_PROD_W'(HUM_SPAN) * HUM_PROD_W'(word_ff);
      h1_ok_ff   <= hum_ok;
      h1_tok_ff  <= tpass_ff;
      h1_temp_ff <= temp_ff;
      h2_q_ff    <= h1_prod_ff[HUM_PROD_W-1:16];
      h2_r_ff    <= {1'b0, h1_prod_ff[15:0]} + 17'(h1_prod_ff[HUM_PROD_W-1:16]);
      h2_ok_ff   <= h1_ok_ff;
      h2_tok_ff  <= h1_tok_ff;
      h2_temp_ff <= h1_temp_ff;
      if (h2_vld_ff) begin
         rsp_data_ff.temperature_tenths <= h2_temp_ff;
         rsp_data_ff.humidity_percent   <= h2_ok_ff ? h_pct : hum_ff;
         rsp_data_ff.temperature_ok     <= h2_tok_ff;
         rsp_data_ff.humidity_ok        <= h2_ok_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      h2_vld_ff |-> !rsp_valid_ff)
      else $error("result reached a full output register");

   a_last_byte_starts_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_byte) |=> h1_vld_ff)
      else $error("final frame byte did not enter the conversion pipe");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_HUM_CRC)
      else $error("byte position out of range");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.humidity_percent <= HUM_SPAN) &&
                       (rsp_data_ff.temperature_tenths >= -12'sd450) &&
                       (rsp_data_ff.temperature_tenths <= 12'sd1300))
      else $error("converted value out of range");

endmodule
